// ===== sv/keyed_count_table_macros.svh =====
// Assertion macros shared by the keyed count table modules.
// Each macro expects clk and rst to be visible in the module that uses it.
`ifndef KEYED_COUNT_TABLE_MACROS_SVH
`define KEYED_COUNT_TABLE_MACROS_SVH

// Same-cycle implication, quiet during reset
`define KCT_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, quiet during reset
`define KCT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/kct_pkg.sv =====
// Shared types and codes for the keyed count table.
// No dependencies; used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package kct_pkg;

  localparam int ENTRIES_DEF = 16;

  // Command codes
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_SEARCH = 2'd1;
  localparam logic [1:0] CMD_UPDATE = 2'd2;
  localparam logic [1:0] CMD_LIST   = 2'd3;

  // Status codes
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_DUP   = 3'd1;
  localparam logic [2:0] ST_MISS  = 3'd2;
  localparam logic [2:0] ST_FULL  = 3'd3;
  localparam logic [2:0] ST_EMPTY = 3'd4;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] part_key;
    logic signed [31:0] amount;
  } cmd_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] entry_key;
    logic signed [31:0] entry_quantity;
    logic               last;
  } res_item_t;

  // Which result the datapath forms when told to load the output register
  typedef enum logic [2:0] {
    RES_FOUND = 3'd0,
    RES_DUP   = 3'd1,
    RES_MISS  = 3'd2,
    RES_FULL  = 3'd3,
    RES_NEW   = 3'd4,
    RES_UPD   = 3'd5,
    RES_EMPTY = 3'd6,
    RES_LIST  = 3'd7
  } res_kind_t;

  // Controller to datapath
  typedef struct packed {
    logic      load_in;
    logic      scan_start;
    logic      write_new;
    logic      write_upd;
    logic      sel_advance;
    logic      out_load;
    res_kind_t kind;
  } ctrl_t;

  // Datapath to controller
  typedef struct packed {
    logic [1:0] command;
    logic       found;
    logic       full;
    logic       empty;
    logic       scan_done;
    logic       list_last;
    logic       out_free;
  } stat_t;

endpackage

// ===== sv/kct_datapath.sv =====
// Datapath of the keyed count table: entry memories, scan engine, match and
// ordered-selection registers, and the output register. Uses kct_pkg.
`timescale 1ns / 1ps
`include "keyed_count_table_macros.svh"

module kct_datapath #(
  parameter int ENTRIES = kct_pkg::ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  kct_pkg::cmd_item_t cmd,
  input  kct_pkg::ctrl_t     ctrl,
  output kct_pkg::stat_t     stat,
  output logic               res_valid,
  input  logic               res_stall,
  output kct_pkg::res_item_t res
);
  import kct_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(ENTRIES);

  cmd_item_t          cmd_reg;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   ptr;
  logic [CNT_W-1:0]   emitted;
  logic               scan_act;
  logic               pend;
  logic [IDX_W-1:0]   pend_idx;
  logic signed [31:0] rd_key;
  logic signed [31:0] rd_qty;
  logic               found;
  logic [IDX_W-1:0]   found_idx;
  logic signed [31:0] found_qty;
  logic               best_valid;
  logic signed [31:0] best_key;
  logic signed [31:0] best_qty;
  logic               have_prev;
  logic signed [31:0] prev_key;

  logic signed [31:0] mem_key [ENTRIES];
  logic signed [31:0] mem_qty [ENTRIES];

  logic               rd_en;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic signed [31:0] wr_qty;
  logic signed [31:0] upd_sum;
  logic               is_match;
  logic               is_cand;
  logic               is_better;
  res_item_t          res_next;

  assign rd_en     = scan_act && (ptr < count);
  assign wr_en     = ctrl.write_new || ctrl.write_upd;
  assign upd_sum   = found_qty + cmd_reg.amount;
  assign wr_addr   = ctrl.write_new ? count[IDX_W-1:0] : found_idx;
  assign wr_qty    = ctrl.write_new ? cmd_reg.amount : upd_sum;
  assign is_match  = (rd_key == cmd_reg.part_key);
  assign is_cand   = !have_prev || (rd_key > prev_key);
  assign is_better = !best_valid || (rd_key < best_key);

  // Entry memories: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_key[wr_addr] <= cmd_reg.part_key;
      mem_qty[wr_addr] <= wr_qty;
    end
    if (rd_en) begin
      rd_key <= mem_key[ptr[IDX_W-1:0]];
      rd_qty <= mem_qty[ptr[IDX_W-1:0]];
    end
  end

  // Command capture
  always_ff @(posedge clk) begin
    if (ctrl.load_in) begin
      cmd_reg <= cmd;
    end
  end

  // Entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctrl.write_new) begin
      count <= count + CNT_W'(1);
    end
  end

  // Scan engine: address pointer and registered read pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_act <= 1'b0;
      ptr      <= '0;
      pend     <= 1'b0;
    end else if (ctrl.scan_start) begin
      scan_act <= 1'b1;
      ptr      <= '0;
      pend     <= 1'b0;
    end else begin
      pend <= rd_en;
      if (rd_en) begin
        ptr <= ptr + CNT_W'(1);
      end
      if (!rd_en && !pend) begin
        scan_act <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      pend_idx <= ptr[IDX_W-1:0];
    end
  end

  // Key match and smallest-key-above-previous selection
  always_ff @(posedge clk) begin
    if (rst) begin
      found      <= 1'b0;
      best_valid <= 1'b0;
    end else if (ctrl.scan_start) begin
      found      <= 1'b0;
      best_valid <= 1'b0;
    end else if (pend) begin
      if (is_match) begin
        found <= 1'b1;
      end
      if (is_cand && is_better) begin
        best_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pend && is_match) begin
      found_idx <= pend_idx;
      found_qty <= rd_qty;
    end
    if (pend && is_cand && is_better) begin
      best_key <= rd_key;
      best_qty <= rd_qty;
    end
  end

  // Ordered listing progress
  always_ff @(posedge clk) begin
    if (rst) begin
      have_prev <= 1'b0;
      emitted   <= '0;
    end else if (ctrl.load_in) begin
      have_prev <= 1'b0;
      emitted   <= '0;
    end else if (ctrl.sel_advance) begin
      have_prev <= 1'b1;
      emitted   <= emitted + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.sel_advance) begin
      prev_key <= best_key;
    end
  end

  // Result formation
  always_comb begin
    res_next.status         = ST_OK;
    res_next.entry_key      = cmd_reg.part_key;
    res_next.entry_quantity = '0;
    res_next.last           = 1'b1;
    case (ctrl.kind)
      RES_FOUND: res_next.entry_quantity = found_qty;
      RES_DUP: begin
        res_next.status         = ST_DUP;
        res_next.entry_quantity = found_qty;
      end
      RES_MISS:  res_next.status = ST_MISS;
      RES_FULL:  res_next.status = ST_FULL;
      RES_NEW:   res_next.entry_quantity = cmd_reg.amount;
      RES_UPD:   res_next.entry_quantity = upd_sum;
      RES_EMPTY: begin
        res_next.status    = ST_EMPTY;
        res_next.entry_key = '0;
      end
      RES_LIST: begin
        res_next.entry_key      = best_key;
        res_next.entry_quantity = best_qty;
        res_next.last           = stat.list_last;
      end
      default: res_next.status = ST_OK;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (ctrl.out_load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      res <= res_next;
    end
  end

  // Status to the controller
  always_comb begin
    stat.command   = cmd_reg.command;
    stat.found     = found;
    stat.full      = (count == CNT_MAX);
    stat.empty     = (count == '0);
    stat.scan_done = !scan_act;
    stat.list_last = ((emitted + CNT_W'(1)) == count);
    stat.out_free  = !res_valid || !res_stall;
  end

  `KCT_ASSERT_IMPLY(a_count_bound, 1'b1, count <= CNT_MAX, "entry count above table size")
  `KCT_ASSERT_NEXT(a_count_step, ctrl.write_new, count == $past(count) + CNT_W'(1), "insert did not grow count")
  `KCT_ASSERT_IMPLY(a_found_valid, found, CNT_W'(found_idx) < count, "match index outside filled entries")

endmodule

// ===== sv/kct_ctrl.sv =====
// Controller of the keyed count table: accepts a command, runs scans and
// decides writes and results. Uses kct_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "keyed_count_table_macros.svh"

module kct_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_stall,
  input  kct_pkg::stat_t stat,
  output kct_pkg::ctrl_t ctrl
);
  import kct_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  assign cmd_stall = (state != S_IDLE);

  // Next state and commands
  always_comb begin
    state_next       = state;
    ctrl.load_in     = 1'b0;
    ctrl.scan_start  = 1'b0;
    ctrl.write_new   = 1'b0;
    ctrl.write_upd   = 1'b0;
    ctrl.sel_advance = 1'b0;
    ctrl.out_load    = 1'b0;
    ctrl.kind        = RES_FOUND;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          ctrl.load_in    = 1'b1;
          ctrl.scan_start = 1'b1;
          state_next      = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.scan_done) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (stat.out_free) begin
          ctrl.out_load = 1'b1;
          state_next    = S_IDLE;
          unique case (stat.command)
            CMD_INSERT: begin
              if (stat.found) begin
                ctrl.kind = RES_DUP;
              end else if (stat.full) begin
                ctrl.kind = RES_FULL;
              end else begin
                ctrl.kind      = RES_NEW;
                ctrl.write_new = 1'b1;
              end
            end
            CMD_SEARCH: ctrl.kind = stat.found ? RES_FOUND : RES_MISS;
            CMD_UPDATE: begin
              if (stat.found) begin
                ctrl.kind      = RES_UPD;
                ctrl.write_upd = 1'b1;
              end else begin
                ctrl.kind = RES_MISS;
              end
            end
            CMD_LIST: begin
              if (stat.empty) begin
                ctrl.kind = RES_EMPTY;
              end else begin
                ctrl.kind        = RES_LIST;
                ctrl.sel_advance = 1'b1;
                // more entries remain: pick the next larger key
                if (!stat.list_last) begin
                  ctrl.scan_start = 1'b1;
                  state_next      = S_SCAN;
                end
              end
            end
            default: ctrl.kind = RES_MISS;
          endcase
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `KCT_ASSERT_IMPLY(a_load_free, ctrl.out_load, stat.out_free, "result loaded over an untaken item")
  `KCT_ASSERT_IMPLY(a_insert_fresh, ctrl.write_new, !stat.found && !stat.full, "insert of present key or into full table")
  `KCT_ASSERT_IMPLY(a_write_after_scan, ctrl.write_new || ctrl.write_upd, stat.scan_done, "table written during a scan")

endmodule

// ===== sv/keyed_count_table.sv =====
// Keyed count table: insert, search, update and ordered list over ENTRIES keys.
// Insert, search and update scan the table, then load their result: one memory read per
// stored entry, read pipeline, scan end and decision.
// List of n entries loads its n items in ascending key order, one full scan per item.
// One command at a time: the next is accepted in the cycle after the last result is loaded,
// later while a held result blocks the output register. Reset (rst) empties the table.
`timescale 1ns / 1ps

module keyed_count_table #(
  parameter int ENTRIES = kct_pkg::ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  kct_pkg::cmd_item_t cmd,
  output logic               res_valid,
  input  logic               res_stall,
  output kct_pkg::res_item_t res
);
  import kct_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  kct_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  kct_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .ctrl      (ctrl),
    .stat      (stat),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule

// ===== tb/sv/kct_checker.sv =====
// Checker for the keyed count table: watches both item channels, keeps its own
// copy of the table, predicts every result and compares field by field.
// Depends on kct_pkg for the item structs, command and status codes.
`timescale 1ns / 1ps

module kct_checker #(
  parameter int ENTRIES = kct_pkg::ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  input  logic               cmd_stall,
  input  kct_pkg::cmd_item_t cmd,
  input  logic               res_valid,
  input  logic               res_stall,
  input  kct_pkg::res_item_t res,
  output int                 fail_count,
  output int                 pending
);
  import kct_pkg::*;

  // Shadow table, in insertion order
  logic signed [31:0] stored_key [ENTRIES];
  logic signed [31:0] stored_qty [ENTRIES];
  int                 stored_count;

  // Results owed by the block, oldest first
  res_item_t results_due[$];
  res_item_t oldest_due;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic res_item_t form_result(logic [2:0] st, logic signed [31:0] k,
                                            logic signed [31:0] q, logic fin);
    res_item_t r;
    r.status         = st;
    r.entry_key      = k;
    r.entry_quantity = q;
    r.last           = fin;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: mismatch on %s: got %h, want %h", $time, what, got, want);
    fail_count++;
  endtask

  // Apply one command to the shadow table and queue the results it owes
  task automatic apply_command(cmd_item_t c);
    logic signed [31:0] sort_key [ENTRIES];
    logic signed [31:0] sort_qty [ENTRIES];
    logic signed [31:0] move_key, move_qty;
    int hit, i, j;
    hit = -1;
    for (i = stored_count - 1; i >= 0; i--)
      if (stored_key[i] == c.part_key) hit = i;
    case (c.command)
      CMD_LIST: begin
        if (stored_count == 0) begin
          results_due.push_back(form_result(ST_EMPTY, '0, '0, 1'b1));
        end else begin
          for (i = 0; i < stored_count; i++) begin
            sort_key[i] = stored_key[i];
            sort_qty[i] = stored_qty[i];
          end
          // ascending signed key order
          for (i = 1; i < stored_count; i++) begin
            move_key = sort_key[i];
            move_qty = sort_qty[i];
            j = i;
            while (j > 0 && move_key < sort_key[j-1]) begin
              sort_key[j] = sort_key[j-1];
              sort_qty[j] = sort_qty[j-1];
              j--;
            end
            sort_key[j] = move_key;
            sort_qty[j] = move_qty;
          end
          for (i = 0; i < stored_count; i++)
            results_due.push_back(form_result(ST_OK, sort_key[i], sort_qty[i],
                                              i == stored_count - 1));
        end
      end
      CMD_INSERT: begin
        // duplicate check wins over the full check
        if (hit >= 0) begin
          results_due.push_back(form_result(ST_DUP, c.part_key, stored_qty[hit], 1'b1));
        end else if (stored_count >= ENTRIES) begin
          results_due.push_back(form_result(ST_FULL, c.part_key, '0, 1'b1));
        end else begin
          stored_key[stored_count] = c.part_key;
          stored_qty[stored_count] = c.amount;
          stored_count++;
          results_due.push_back(form_result(ST_OK, c.part_key, c.amount, 1'b1));
        end
      end
      default: begin
        // search and update
        if (hit < 0) begin
          results_due.push_back(form_result(ST_MISS, c.part_key, '0, 1'b1));
        end else begin
          if (c.command == CMD_UPDATE) stored_qty[hit] = stored_qty[hit] + c.amount;
          results_due.push_back(form_result(ST_OK, c.part_key, stored_qty[hit], 1'b1));
        end
      end
    endcase
  endtask

  // Sample both channels at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      stored_count = 0;
      results_due.delete();
    end else begin
      if (cmd_valid && !cmd_stall) apply_command(cmd);
      if (res_valid && !res_stall) begin
        if (results_due.size() == 0) begin
          report_mismatch("result with nothing due, key", res.entry_key, '0);
        end else begin
          oldest_due = results_due.pop_front();
          if (res.status !== oldest_due.status)
            report_mismatch("status", 32'(res.status), 32'(oldest_due.status));
          if (res.entry_key !== oldest_due.entry_key)
            report_mismatch("entry_key", res.entry_key, oldest_due.entry_key);
          if (res.entry_quantity !== oldest_due.entry_quantity)
            report_mismatch("entry_quantity", res.entry_quantity,
                            oldest_due.entry_quantity);
          if (res.last !== oldest_due.last)
            report_mismatch("last", 32'(res.last), 32'(oldest_due.last));
        end
      end
    end
    pending = results_due.size();
  end

endmodule

// ===== tb/sv/tb_keyed_count_table.sv =====
// Testbench top for the keyed count table: clock, reset, command stimulus,
// receiver stalls and the verdict. Needs kct_pkg, keyed_count_table and kct_checker.
`timescale 1ns / 1ps

module tb_keyed_count_table;
  import kct_pkg::*;

  localparam int POOL_SIZE    = 20;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 400;
  localparam int CYCLE_LIMIT  = 400000;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      cmd_valid = 1'b0;
  logic      cmd_stall;
  cmd_item_t cmd       = '0;
  logic      res_valid;
  logic      res_stall = 1'b0;
  res_item_t res;

  int fail_count;
  int pending;
  int cycle_count   = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req      = 0;
  int hold_seen     = 0;
  int hold_left     = 0;

  // Keys most commands draw from, so that hits, duplicates and a full table occur
  logic signed [31:0] key_pool [POOL_SIZE];

  always #5 clk = ~clk;

  keyed_count_table uut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  kct_checker table_check (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .cmd        (cmd),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res        (res),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Receiver: random stalls, or a long hold-off when one is requested
  always @(negedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES - 1;
      res_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      res_stall <= 1'b1;
    end else begin
      res_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("keyed_count_table test failed");
      $finish;
    end
  end

  function automatic cmd_item_t pack_command(logic [1:0] op, logic [31:0] k,
                                             logic [31:0] a);
    cmd_item_t c;
    c.command  = op;
    c.part_key = k;
    c.amount   = a;
    return c;
  endfunction

  // Mostly pool keys with random quantities; some fully random keys as noise
  function automatic cmd_item_t random_command();
    cmd_item_t c;
    int pick;
    pick = $urandom_range(99);
    if (pick < 40)      c.command = CMD_INSERT;
    else if (pick < 62) c.command = CMD_SEARCH;
    else if (pick < 85) c.command = CMD_UPDATE;
    else                c.command = CMD_LIST;
    c.part_key = ($urandom_range(99) < 85) ? key_pool[$urandom_range(POOL_SIZE - 1)]
                                           : $urandom;
    c.amount = ($urandom_range(99) < 30) ? $urandom_range(20) - 10 : $urandom;
    return c;
  endfunction

  // Offer one item after a random gap and hold it until accepted
  task automatic send_item(cmd_item_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      cmd_valid <= 1'b0;
    end
    @(negedge clk);
    cmd_valid <= 1'b1;
    cmd       <= item;
    // stall only moves at the rising edge, so it is settled at the falling one
    while (cmd_stall) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic send_random(int count);
    for (int n = 0; n < count; n++) send_item(random_command());
  endtask

  // Stop offering and wait for every owed result
  task automatic wait_all_results();
    @(negedge clk);
    cmd_valid <= 1'b0;
    wait (pending == 0);
  endtask

  initial begin
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7fff_ffff;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hffff_ffff;
    for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom;

    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // Phase one: sender idles a little, receiver a lot
    send_idle_pct = 18;
    recv_idle_pct = 48;

    // Directed: empty table, misses, extreme keys and quantities, duplicate, wrap
    send_item(pack_command(CMD_LIST,   $urandom,     $urandom));
    send_item(pack_command(CMD_SEARCH, 32'h0,        $urandom));
    send_item(pack_command(CMD_UPDATE, 32'h7fffffff, 32'h7fffffff));
    send_item(pack_command(CMD_INSERT, 32'h80000000, 32'h7fffffff));
    send_item(pack_command(CMD_INSERT, 32'h7fffffff, 32'h80000000));
    send_item(pack_command(CMD_INSERT, 32'h0,        32'hffffffff));
    send_item(pack_command(CMD_INSERT, 32'hffffffff, 32'h0));
    send_item(pack_command(CMD_INSERT, 32'h80000000, 32'h5));
    send_item(pack_command(CMD_UPDATE, 32'h80000000, 32'h1));
    send_item(pack_command(CMD_UPDATE, 32'h7fffffff, 32'hffffffff));
    send_item(pack_command(CMD_UPDATE, 32'h0,        32'h80000000));
    send_item(pack_command(CMD_SEARCH, 32'hffffffff, $urandom));
    send_item(pack_command(CMD_SEARCH, 32'h7fffffff, $urandom));
    send_item(pack_command(CMD_LIST,   $urandom,     $urandom));

    send_random(34);
    wait_all_results();

    // Phase two: roles swapped
    send_idle_pct = 48;
    recv_idle_pct = 18;
    send_random(33);
    wait_all_results();

    // Phase three: no idling, opened by a long receiver hold-off
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req++;
    send_random(33);
    wait_all_results();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("keyed_count_table test passed");
    end else begin
      $display("keyed_count_table test failed");
    end
    $finish;
  end

endmodule
